@@ rtl/mnpi_pkg.sv @@
// mnpi_pkg: shared types, constants and note tables of the midi note pulse interrupter
// no dependencies; imported by every module of the block

package mnpi_pkg;

  // timer ticks per microsecond of the tick stream
  localparam int unsigned TICKS_PER_MICROSECOND = 2;

  localparam int unsigned CHAN_W  = 5;
  localparam int unsigned PITCH_W = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned CMP_W   = 18;
  localparam int unsigned PULSE_W = 8;
  localparam int unsigned NOTES   = 128;

  localparam logic [CHAN_W-1:0] LISTEN_RESET = CHAN_W'(1);
  localparam int unsigned CMP_MAX   = (1 << CMP_W) - 1;
  localparam int unsigned PULSE_MAX = (1 << PULSE_W) - 1;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_NOTE = 1'b1;

  localparam int unsigned USEC = 1000000;

  typedef struct packed {
    logic [VEL_W-1:0]   velocity;
    logic [PITCH_W-1:0] pitch;
    logic [CHAN_W-1:0]  channel;
    logic               mode;
  } item_t;

  typedef struct packed {
    logic playing;
    logic drive;
  } result_t;

  // equal-tempered note frequency in hertz, rounded
  localparam int unsigned NOTE_FREQ [NOTES] = '{
    8, 9, 9, 10, 10, 11, 12, 12, 13, 14, 15, 15,
    16, 17, 18, 19, 21, 22, 23, 24, 26, 28, 29, 31,
    33, 35, 37, 39, 41, 44, 46, 49, 52, 55, 58, 62,
    65, 69, 73, 78, 82, 87, 92, 98, 104, 110, 117, 123,
    131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247,
    262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
    523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988,
    1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976,
    2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951,
    4186, 4435, 4699, 4978, 5274, 5588, 5920, 6272, 6645, 7040, 7459, 7902,
    8372, 8870, 9397, 9956, 10548, 11175, 11840, 12544
  };

  // note period in whole microseconds, truncated
  localparam int unsigned PERIOD_US [NOTES] = '{
    USEC/8, USEC/9, USEC/9, USEC/10, USEC/10, USEC/11, USEC/12, USEC/12,
    USEC/13, USEC/14, USEC/15, USEC/15,
    USEC/16, USEC/17, USEC/18, USEC/19, USEC/21, USEC/22, USEC/23, USEC/24,
    USEC/26, USEC/28, USEC/29, USEC/31,
    USEC/33, USEC/35, USEC/37, USEC/39, USEC/41, USEC/44, USEC/46, USEC/49,
    USEC/52, USEC/55, USEC/58, USEC/62,
    USEC/65, USEC/69, USEC/73, USEC/78, USEC/82, USEC/87, USEC/92, USEC/98,
    USEC/104, USEC/110, USEC/117, USEC/123,
    USEC/131, USEC/139, USEC/147, USEC/156, USEC/165, USEC/175, USEC/185,
    USEC/196, USEC/208, USEC/220, USEC/233, USEC/247,
    USEC/262, USEC/277, USEC/294, USEC/311, USEC/330, USEC/349, USEC/370,
    USEC/392, USEC/415, USEC/440, USEC/466, USEC/494,
    USEC/523, USEC/554, USEC/587, USEC/622, USEC/659, USEC/698, USEC/740,
    USEC/784, USEC/831, USEC/880, USEC/932, USEC/988,
    USEC/1047, USEC/1109, USEC/1175, USEC/1245, USEC/1319, USEC/1397,
    USEC/1480, USEC/1568, USEC/1661, USEC/1760, USEC/1865, USEC/1976,
    USEC/2093, USEC/2217, USEC/2349, USEC/2489, USEC/2637, USEC/2794,
    USEC/2960, USEC/3136, USEC/3322, USEC/3520, USEC/3729, USEC/3951,
    USEC/4186, USEC/4435, USEC/4699, USEC/4978, USEC/5274, USEC/5588,
    USEC/5920, USEC/6272, USEC/6645, USEC/7040, USEC/7459, USEC/7902,
    USEC/8372, USEC/8870, USEC/9397, USEC/9956, USEC/10548, USEC/11175,
    USEC/11840, USEC/12544
  };

  // period compare value in ticks, saturated to the counter width
  function automatic logic [CMP_W-1:0] note_compare(input logic [PITCH_W-1:0] pitch);
    int unsigned ticks;
    ticks = TICKS_PER_MICROSECOND * PERIOD_US[pitch];
    if (ticks > CMP_MAX) begin
      return CMP_W'(CMP_MAX);
    end
    return CMP_W'(ticks);
  endfunction

  // pulse length in ticks: on-time step by frequency, times TICKS_PER_MICROSECOND, saturated
  function automatic logic [PULSE_W-1:0] note_pulse(input logic [PITCH_W-1:0] pitch);
    int unsigned f;
    int unsigned us;
    int unsigned ticks;
    f = NOTE_FREQ[pitch];
    if (f < 100) us = 67;
    else if (f < 200) us = 60;
    else if (f < 300) us = 52;
    else if (f < 400) us = 45;
    else if (f < 500) us = 40;
    else if (f < 600) us = 34;
    else if (f < 800) us = 30;
    else if (f < 900) us = 27;
    else us = 25;
    ticks = TICKS_PER_MICROSECOND * us;
    if (ticks > PULSE_MAX) begin
      return PULSE_W'(PULSE_MAX);
    end
    return PULSE_W'(ticks);
  endfunction

endpackage

@@ rtl/mnpi_input_stage.sv @@
// mnpi_input_stage: input register holding one request ahead of the core
// depends on mnpi_pkg

module mnpi_input_stage
  import mnpi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_d, valid_q;
  item_t item_q;

  // free slot, or the held request moves on this cycle
  assign ready_o = !valid_q || advance_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/mnpi_core.sv @@
// mnpi_core: note state, period counter and pulse timer; next result per request
// depends on mnpi_pkg

module mnpi_core
  import mnpi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CHAN_W-1:0] cfg_wdata_i,
  input  logic              advance_i,
  input  item_t             item_i,
  output result_t           result_o
);

  logic [CHAN_W-1:0]  listen_q;
  logic               playing_d, playing_q;
  logic [PITCH_W-1:0] pitch_d, pitch_q;
  logic [CMP_W-1:0]   compare_d, compare_q;
  logic [CMP_W-1:0]   count_d, count_q;
  logic [PULSE_W-1:0] len_d, len_q;
  logic [PULSE_W-1:0] left_d, left_q;
  logic [CMP_W-1:0]   count_inc;

  assign count_inc = count_q + CMP_W'(1);

  always_comb begin
    playing_d = playing_q;
    pitch_d   = pitch_q;
    compare_d = compare_q;
    count_d   = count_q;
    len_d     = len_q;
    left_d    = left_q;
    if (item_i.mode == MODE_TICK) begin
      if (left_q != '0) begin
        left_d = left_q - PULSE_W'(1);
      end
      if (playing_q) begin
        count_d = count_inc;
        if (count_inc >= compare_q) begin
          count_d = '0;
          left_d  = len_q;
        end
      end
    end else if (item_i.channel == listen_q) begin
      if (item_i.velocity == '0) begin
        if (item_i.pitch == pitch_q) begin
          playing_d = 1'b0;
        end
      end else begin
        pitch_d   = item_i.pitch;
        compare_d = note_compare(item_i.pitch);
        len_d     = note_pulse(item_i.pitch);
        count_d   = '0;
        playing_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q  <= LISTEN_RESET;
      playing_q <= 1'b0;
      pitch_q   <= '0;
      compare_q <= '0;
      count_q   <= '0;
      len_q     <= '0;
      left_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        listen_q <= cfg_wdata_i;
      end
      if (advance_i) begin
        playing_q <= playing_d;
        pitch_q   <= pitch_d;
        compare_q <= compare_d;
        count_q   <= count_d;
        len_q     <= len_d;
        left_q    <= left_d;
      end
    end
  end

  assign result_o.drive   = (left_d != '0);
  assign result_o.playing = playing_d;

endmodule

@@ rtl/mnpi_output_stage.sv @@
// mnpi_output_stage: result register towards the downstream side
// depends on mnpi_pkg

module mnpi_output_stage
  import mnpi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    ready_i,
  output logic    valid_o,
  output result_t result_o
);

  logic    valid_d, valid_q;
  result_t result_q;

  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ rtl/midi_note_pulse_interrupter.sv @@
// midi_note_pulse_interrupter: top level of the monophonic midi pulse interrupter
// depends on mnpi_pkg, mnpi_input_stage, mnpi_core, mnpi_output_stage

// Monophonic midi interrupter. Each input request is either one timer tick
// (tuser = 0, one tick is 1/TICKS_PER_MICROSECOND microseconds) or a note event
// (tuser = 1). A note-on on the listened channel stores its pitch, loads the
// period and pulse length from constant tables and restarts the period
// counter; a note-off with the held pitch stops it. While a note plays, the
// period counter wraps at the compare value and starts a drive pulse, and a
// pulse that has started always runs to its end. Every request gives exactly
// one result (drive, playing). Throughput is one request per clock cycle while
// the result stream is not stalled. An accepted request waits in the input
// register while the note tables and the 18-bit counter compare work out its
// result, which is loaded into the result register when the request advances.
// The user must write the channel register with cfg_we_i only while no request
// is in flight; the block itself does not enforce this. It resets to channel 1.

module midi_note_pulse_interrupter
  import mnpi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: listened channel
  input  logic              cfg_we_i,
  input  logic [CHAN_W-1:0] cfg_wdata_i,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: channel[4:0], pitch[11:5], velocity[18:12], zero pad
  input  logic [23:0]       s_axis_tdata,
  // tuser: mode (0 tick, 1 note event)
  input  logic              s_axis_tuser,
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tdata from bit 0: drive, playing, zero pad
  output logic [7:0]        m_axis_tdata
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_valid;
  logic    advance;
  result_t next_result;
  result_t out_result;

  // unpack the request, padding bits are dropped
  assign in_item.mode     = s_axis_tuser;
  assign in_item.channel  = s_axis_tdata[CHAN_W-1:0];
  assign in_item.pitch    = s_axis_tdata[CHAN_W+PITCH_W-1:CHAN_W];
  assign in_item.velocity = s_axis_tdata[CHAN_W+PITCH_W+VEL_W-1:CHAN_W+PITCH_W];

  // the held request moves into the result register whenever that register
  // is empty or is being emptied in the same cycle
  assign advance = held_valid && (!out_valid || m_axis_tready);

  mnpi_input_stage u_input_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  // note state only changes on advance, so a stalled request is seen once
  mnpi_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (held_item),
    .result_o    (next_result)
  );

  mnpi_output_stage u_output_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (next_result),
    .ready_i  (m_axis_tready),
    .valid_o  (out_valid),
    .result_o (out_result)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_result.playing, out_result.drive};

  // a request moved to the output is waiting there next cycle
  a_advance_fills_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid
  ) else $error("result register empty after a request advanced");

  // a held request that cannot move keeps its slot and its contents
  a_held_request_kept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    held_valid && !advance |=> held_valid && $stable(held_item)
  ) else $error("held request lost or changed while stalled");

  // a stalled result is neither dropped nor overwritten
  a_stalled_result_kept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid && !m_axis_tready |=> out_valid && $stable(out_result)
  ) else $error("stalled result lost or changed");

endmodule
